/* design/bsim_pkg.sv */
// shared types, codes and constants of the bank switch and interrupt mapper
package bsim_pkg;

  localparam int NUM_BANK_REGS = 11;
  localparam int BANK_SEL_W    = 4;

  // request types of the input word
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_SCAN  = 2'd2,
    REQ_INIT  = 2'd3
  } req_t;

  // result actions
  typedef enum logic [2:0] {
    ACT_PRG    = 3'd0,
    ACT_CHR    = 3'd1,
    ACT_MIRROR = 3'd2,
    ACT_RAISE  = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_t;

  // cpu register decode
  localparam logic [15:0] ADDR_MASK    = 16'hF001;
  localparam logic [15:0] ADDR_CMD     = 16'h8000;
  localparam logic [15:0] ADDR_BANK    = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR  = 16'hA000;
  localparam logic [15:0] ADDR_LATCH   = 16'hC000;
  localparam logic [15:0] ADDR_RELOAD  = 16'hC001;
  localparam logic [15:0] ADDR_DISABLE = 16'hE000;
  localparam logic [15:0] ADDR_ENABLE  = 16'hE001;

  // command byte fields
  localparam int                    PAIR_BIT       = 5;
  localparam logic [BANK_SEL_W-1:0] BANK_SEL_LIMIT = 4'd10;
  localparam logic [BANK_SEL_W-1:0] BANK_SEL_ALT   = 4'hF;
  localparam logic [BANK_SEL_W-1:0] BANK_REG_ALT   = 4'd10;

  // configuration register indexes
  localparam int               CFG_IDX_W       = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIRROR = 2'd2;
  localparam logic [7:0]       PRG_COUNT_RESET = 8'd2;

  localparam logic [7:0] MIRROR_VERT = 8'd0;
  localparam logic [7:0] MIRROR_HORZ = 8'd1;
  localparam logic [7:0] BANK_RESET  = 8'hFF;

  // slot load sequence: positions 0..3 program, 4..11 character
  localparam int            SEQ_LEN       = 12;
  localparam int            SEQ_W         = 4;
  localparam logic [SEQ_W-1:0] SEQ_FIXED     = 4'd3;
  localparam logic [SEQ_W-1:0] SEQ_CHR_FIRST = 4'd4;
  localparam logic [SEQ_W-1:0] SEQ_PAIR_END  = 4'd8;
  localparam logic [SEQ_W-1:0] SEQ_LAST      = 4'd11;

  // bank register feeding each sequence position, 1 KB and 2 KB-paired layouts
  localparam logic [BANK_SEL_W-1:0] SRC_1K [SEQ_LEN] = '{
    4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd3, 4'd4, 4'd5
  };
  localparam logic [BANK_SEL_W-1:0] SRC_2K [SEQ_LEN] = '{
    4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5
  };

  // shared remainder unit
  localparam int DIV_W          = 10;
  localparam int DVSR_W         = 8;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = 3;

  // decoded operation of the captured word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CMD,
    OP_BANK,
    OP_MIRROR,
    OP_LATCH,
    OP_RELOAD,
    OP_DISABLE,
    OP_ENABLE,
    OP_TICK,
    OP_SCAN,
    OP_INIT
  } op_t;

  // what the output stage loads
  typedef enum logic [2:0] {
    EK_BANK,
    EK_MIRROR_WR,
    EK_MIRROR_INIT,
    EK_CLEAR,
    EK_RAISE
  } emit_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BANK,
    ST_BDIV,
    ST_TDIV,
    ST_TICK,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic             capture;
    logic             exec;
    logic             div_start;
    logic             div_tick;
    logic             tick_apply;
    logic             emit;
    emit_kind_t       kind;
    logic [SEQ_W-1:0] idx;
    logic             last;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic raise_now;
    logic tick_raise;
    logic div_busy;
    logic out_free;
    logic chr_none;
  } dp_status_t;

endpackage

/* design/bsim_div.sv */
// iterative restoring divider, two quotient bits per cycle
module bsim_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bsim_pkg::DIV_W-1:0]   dividend,
  input  logic [bsim_pkg::DVSR_W-1:0]  divisor,
  output logic                         busy,
  output logic [bsim_pkg::DIV_W-1:0]   quotient,
  output logic [bsim_pkg::DIV_W-1:0]   remainder
);

  localparam int TRIAL_W = bsim_pkg::DIV_W + 1;

  logic [bsim_pkg::DIV_W-1:0]     rem_acc;
  logic [bsim_pkg::DIV_W-1:0]     quo_acc;
  logic [bsim_pkg::DIV_W-1:0]     rem_next;
  logic [bsim_pkg::DIV_W-1:0]     quo_next;
  logic [bsim_pkg::DVSR_W-1:0]    dvsr;
  logic [bsim_pkg::DIV_CNT_W-1:0] cnt;

  // zero divisor leaves the dividend in the remainder
  always_comb begin : div_step
    logic [TRIAL_W-1:0] trial;
    rem_next = rem_acc;
    quo_next = quo_acc;
    trial    = '0;
    for (int k = 0; k < bsim_pkg::DIV_RADIX_BITS; k++) begin
      trial    = {rem_next, quo_next[bsim_pkg::DIV_W-1]};
      quo_next = {quo_next[bsim_pkg::DIV_W-2:0], 1'b0};
      if (trial >= TRIAL_W'(dvsr)) begin
        trial       = trial - TRIAL_W'(dvsr);
        quo_next[0] = 1'b1;
      end
      rem_next = trial[bsim_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= bsim_pkg::DIV_CNT_W'(bsim_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - bsim_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_acc <= '0;
      quo_acc <= dividend;
      dvsr    <= divisor;
    end else if (busy) begin
      rem_acc <= rem_next;
      quo_acc <= quo_next;
    end
  end

  assign quotient  = quo_acc;
  assign remainder = rem_acc;

endmodule

/* design/bsim_dp.sv */
// datapath: captured word, mapper state, config, remainder unit and output stage
module bsim_dp #(
  parameter int CYCLE_PRESCALE = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bsim_pkg::ctrl_cmd_t            cmd,
  output bsim_pkg::dp_status_t           status,
  input  logic                           cfg_write,
  input  logic [bsim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic [1:0]                     req_type,
  input  logic [15:0]                    address,
  input  logic [7:0]                     data,
  input  logic [7:0]                     cycles,
  input  logic                           rendering_on,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [2:0]                     action,
  output logic [2:0]                     slot,
  output logic [7:0]                     bank,
  output logic                           last
);

  localparam int RES_W = (CYCLE_PRESCALE > 2) ? $clog2(CYCLE_PRESCALE) : 1;

  // captured word
  logic [1:0]  it_req;
  logic [15:0] it_addr;
  logic [7:0]  it_data;
  logic [7:0]  it_cycles;
  logic        it_render;

  // configuration
  logic [7:0] prg_banks;
  logic [7:0] chr_banks;
  logic       init_mirror;

  // mapper state
  logic [7:0]       command;
  logic [7:0]       bank_regs [bsim_pkg::NUM_BANK_REGS];
  logic             cycle_mode;
  logic             irq_enabled;
  logic [7:0]       irq_count;
  logic [7:0]       reload_value;
  logic             reload_pending;
  logic [RES_W-1:0] residue;

  bsim_pkg::op_t                    op;
  logic                             clear_state;
  logic [bsim_pkg::BANK_SEL_W-1:0]  bank_sel;
  logic [bsim_pkg::BANK_SEL_W-1:0]  src;
  logic [7:0]                       opnd;
  logic [bsim_pkg::DIV_W-1:0]       tick_sum;
  logic [bsim_pkg::DIV_W-1:0]       div_dividend;
  logic [bsim_pkg::DVSR_W-1:0]      div_divisor;
  logic                             div_busy;
  logic [bsim_pkg::DIV_W-1:0]       div_quo;
  logic [bsim_pkg::DIV_W-1:0]       div_rem;
  logic                             pair_mode;
  logic                             out_free;
  logic                             out_valid_next;
  bsim_pkg::act_t                   res_action;
  logic [2:0]                       res_slot;
  logic [7:0]                       res_bank;
  bsim_pkg::act_t                   action_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_req    <= req_type;
      it_addr   <= address;
      it_data   <= data;
      it_cycles <= cycles;
      it_render <= rendering_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks   <= bsim_pkg::PRG_COUNT_RESET;
      chr_banks   <= '0;
      init_mirror <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsim_pkg::CFG_PRG_COUNT:   prg_banks   <= cfg_data;
        bsim_pkg::CFG_CHR_COUNT:   chr_banks   <= cfg_data;
        bsim_pkg::CFG_INIT_MIRROR: init_mirror <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op = bsim_pkg::OP_NONE;
    unique case (bsim_pkg::req_t'(it_req))
      bsim_pkg::REQ_WRITE: begin
        unique case (it_addr & bsim_pkg::ADDR_MASK)
          bsim_pkg::ADDR_CMD:     op = bsim_pkg::OP_CMD;
          bsim_pkg::ADDR_BANK:    op = bsim_pkg::OP_BANK;
          bsim_pkg::ADDR_MIRROR:  op = bsim_pkg::OP_MIRROR;
          bsim_pkg::ADDR_LATCH:   op = bsim_pkg::OP_LATCH;
          bsim_pkg::ADDR_RELOAD:  op = bsim_pkg::OP_RELOAD;
          bsim_pkg::ADDR_DISABLE: op = bsim_pkg::OP_DISABLE;
          bsim_pkg::ADDR_ENABLE:  op = bsim_pkg::OP_ENABLE;
          default:                op = bsim_pkg::OP_NONE;
        endcase
      end
      bsim_pkg::REQ_TICK: op = cycle_mode ? bsim_pkg::OP_TICK : bsim_pkg::OP_NONE;
      bsim_pkg::REQ_SCAN: begin
        op = (!cycle_mode && it_render) ? bsim_pkg::OP_SCAN : bsim_pkg::OP_NONE;
      end
      bsim_pkg::REQ_INIT: op = bsim_pkg::OP_INIT;
      default:            op = bsim_pkg::OP_NONE;
    endcase
  end

  assign clear_state = rst || (cmd.exec && op == bsim_pkg::OP_INIT);
  assign bank_sel    = command[bsim_pkg::BANK_SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (clear_state) begin
      command        <= '0;
      for (int i = 0; i < bsim_pkg::NUM_BANK_REGS; i++) begin
        bank_regs[i] <= bsim_pkg::BANK_RESET;
      end
      cycle_mode     <= 1'b0;
      irq_enabled    <= 1'b0;
      irq_count      <= '0;
      reload_value   <= '0;
      reload_pending <= 1'b0;
      residue        <= '0;
    end else if (cmd.exec) begin
      unique case (op)
        bsim_pkg::OP_CMD: command <= it_data;
        bsim_pkg::OP_BANK: begin
          if (bank_sel < bsim_pkg::BANK_SEL_LIMIT) begin
            bank_regs[bank_sel] <= it_data;
          end else if (bank_sel == bsim_pkg::BANK_SEL_ALT) begin
            bank_regs[bsim_pkg::BANK_REG_ALT] <= it_data;
          end
        end
        bsim_pkg::OP_LATCH: begin
          reload_value <= it_data;
          if (reload_pending) irq_count <= it_data;
        end
        bsim_pkg::OP_RELOAD: begin
          reload_pending <= 1'b1;
          irq_count      <= reload_value;
          cycle_mode     <= it_data[0];
        end
        bsim_pkg::OP_DISABLE: begin
          irq_enabled <= 1'b0;
          if (reload_pending) irq_count <= reload_value;
        end
        bsim_pkg::OP_ENABLE: begin
          irq_enabled <= 1'b1;
          if (reload_pending) irq_count <= reload_value;
        end
        bsim_pkg::OP_SCAN: begin
          // a wrap while enabled re-arms the reload
          irq_count      <= irq_count - 8'd1;
          reload_pending <= (irq_count == '0) && irq_enabled;
        end
        default: ;
      endcase
    end else if (cmd.tick_apply) begin
      irq_count <= irq_count - div_quo[7:0];
      residue   <= div_rem[RES_W-1:0];
    end
  end

  // operand for the current slot load
  assign pair_mode = !command[bsim_pkg::PAIR_BIT];

  always_comb begin
    src  = pair_mode ? bsim_pkg::SRC_2K[cmd.idx] : bsim_pkg::SRC_1K[cmd.idx];
    opnd = bank_regs[src];
    if (pair_mode && cmd.idx >= bsim_pkg::SEQ_CHR_FIRST && cmd.idx < bsim_pkg::SEQ_PAIR_END) begin
      opnd = {opnd[7:1], cmd.idx[0]};
    end
  end

  assign tick_sum = bsim_pkg::DIV_W'(residue) + bsim_pkg::DIV_W'(it_cycles);

  always_comb begin
    if (cmd.div_tick) begin
      div_dividend = tick_sum;
      div_divisor  = bsim_pkg::DVSR_W'(CYCLE_PRESCALE);
    end else begin
      div_dividend = bsim_pkg::DIV_W'(opnd);
      div_divisor  = (cmd.idx < bsim_pkg::SEQ_CHR_FIRST) ? prg_banks : chr_banks;
    end
  end

  bsim_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // result selection
  always_comb begin
    res_action = bsim_pkg::ACT_CLEAR;
    res_slot   = '0;
    res_bank   = '0;
    unique case (cmd.kind)
      bsim_pkg::EK_BANK: begin
        if (cmd.idx < bsim_pkg::SEQ_CHR_FIRST) begin
          res_action = bsim_pkg::ACT_PRG;
          res_slot   = cmd.idx[2:0];
          res_bank   = (cmd.idx == bsim_pkg::SEQ_FIXED) ? prg_banks - 8'd1 : div_rem[7:0];
        end else begin
          res_action = bsim_pkg::ACT_CHR;
          res_slot   = 3'(cmd.idx - bsim_pkg::SEQ_CHR_FIRST);
          res_bank   = div_rem[7:0];
        end
      end
      bsim_pkg::EK_MIRROR_WR: begin
        res_action = bsim_pkg::ACT_MIRROR;
        res_bank   = {7'd0, it_data[0]};
      end
      bsim_pkg::EK_MIRROR_INIT: begin
        res_action = bsim_pkg::ACT_MIRROR;
        res_bank   = init_mirror ? bsim_pkg::MIRROR_VERT : bsim_pkg::MIRROR_HORZ;
      end
      bsim_pkg::EK_RAISE: res_action = bsim_pkg::ACT_RAISE;
      default:            res_action = bsim_pkg::ACT_CLEAR;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      action_r <= res_action;
      slot     <= res_slot;
      bank     <= res_bank;
      last     <= cmd.last;
    end
  end

  assign action = action_r;

  assign status.op         = op;
  assign status.raise_now  = (irq_count == '0) && irq_enabled;
  assign status.tick_raise = irq_enabled && (div_quo > bsim_pkg::DIV_W'(irq_count));
  assign status.div_busy   = div_busy;
  assign status.out_free   = out_free;
  assign status.chr_none   = (chr_banks == '0);

endmodule

/* design/bsim_ctrl.sv */
// controller: sequences execution, slot loads, divisions and result words
module bsim_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsim_pkg::dp_status_t status,
  output bsim_pkg::ctrl_cmd_t  cmd
);

  bsim_pkg::ctrl_state_t           state;
  bsim_pkg::ctrl_state_t           state_next;
  logic [bsim_pkg::SEQ_W-1:0]      idx;
  logic [bsim_pkg::SEQ_W-1:0]      idx_next;
  bsim_pkg::emit_kind_t            kind;
  bsim_pkg::emit_kind_t            kind_next;
  logic                            bank_end;
  logic                            is_init;

  assign bank_end = (idx == bsim_pkg::SEQ_LAST) ||
                    (idx == bsim_pkg::SEQ_FIXED && status.chr_none);
  assign is_init  = (status.op == bsim_pkg::OP_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsim_pkg::ST_IDLE;
      idx   <= '0;
      kind  <= bsim_pkg::EK_BANK;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    kind_next  = kind;
    unique case (state)
      bsim_pkg::ST_IDLE: begin
        if (in_valid) state_next = bsim_pkg::ST_EXEC;
      end
      bsim_pkg::ST_EXEC: begin
        unique case (status.op) inside
          bsim_pkg::OP_BANK, bsim_pkg::OP_INIT: begin
            state_next = bsim_pkg::ST_BANK;
            idx_next   = '0;
            kind_next  = bsim_pkg::EK_BANK;
          end
          bsim_pkg::OP_MIRROR: begin
            state_next = bsim_pkg::ST_EMIT;
            kind_next  = bsim_pkg::EK_MIRROR_WR;
          end
          bsim_pkg::OP_DISABLE: begin
            state_next = bsim_pkg::ST_EMIT;
            kind_next  = bsim_pkg::EK_CLEAR;
          end
          bsim_pkg::OP_SCAN: begin
            if (status.raise_now) begin
              state_next = bsim_pkg::ST_EMIT;
              kind_next  = bsim_pkg::EK_RAISE;
            end else begin
              state_next = bsim_pkg::ST_IDLE;
            end
          end
          bsim_pkg::OP_TICK: state_next = bsim_pkg::ST_TDIV;
          default:           state_next = bsim_pkg::ST_IDLE;
        endcase
      end
      bsim_pkg::ST_BANK: begin
        state_next = (idx == bsim_pkg::SEQ_FIXED) ? bsim_pkg::ST_EMIT : bsim_pkg::ST_BDIV;
      end
      bsim_pkg::ST_BDIV: begin
        if (!status.div_busy) state_next = bsim_pkg::ST_EMIT;
      end
      bsim_pkg::ST_TDIV: begin
        if (!status.div_busy) state_next = bsim_pkg::ST_TICK;
      end
      bsim_pkg::ST_TICK: begin
        if (status.tick_raise) begin
          state_next = bsim_pkg::ST_EMIT;
          kind_next  = bsim_pkg::EK_RAISE;
        end else begin
          state_next = bsim_pkg::ST_IDLE;
        end
      end
      bsim_pkg::ST_EMIT: begin
        if (status.out_free) begin
          if (kind == bsim_pkg::EK_BANK) begin
            if (!bank_end) begin
              idx_next   = idx + bsim_pkg::SEQ_W'(1);
              state_next = bsim_pkg::ST_BANK;
            end else if (is_init) begin
              kind_next  = bsim_pkg::EK_MIRROR_INIT;
            end else begin
              state_next = bsim_pkg::ST_IDLE;
            end
          end else begin
            state_next = bsim_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = bsim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != bsim_pkg::ST_IDLE);
    cmd.capture    = (state == bsim_pkg::ST_IDLE) && in_valid;
    cmd.exec       = (state == bsim_pkg::ST_EXEC);
    cmd.div_tick   = (state == bsim_pkg::ST_EXEC);
    cmd.div_start  = ((state == bsim_pkg::ST_EXEC) && (status.op == bsim_pkg::OP_TICK)) ||
                     ((state == bsim_pkg::ST_BANK) && (idx != bsim_pkg::SEQ_FIXED));
    cmd.tick_apply = (state == bsim_pkg::ST_TICK);
    cmd.emit       = (state == bsim_pkg::ST_EMIT) && status.out_free;
    cmd.kind       = kind;
    cmd.idx        = idx;
    cmd.last       = (kind == bsim_pkg::EK_BANK) ? (bank_end && !is_init) : 1'b1;
  end

endmodule

/* design/bank_switch_irq_mapper_core.sv */
// top level of the cartridge bank switch and interrupt mapper
//
// input channel: one word per request (register write, cpu tick, scanline,
// initialize), accepted on in_valid high with in_stall low. in_stall is high
// while a word is in work; one word is handled at a time.
// output channel: result words (slot loads, mirroring, interrupt raise and
// clear) on out_valid/out_stall, last marks the final word of a request.
// config port: cfg_write with cfg_index and cfg_data, written into registers.
// bank loads: every reduced bank number goes through a shared remainder unit
// that retires two bits a cycle; each such slot load passes setup, divide and
// output load steps, while the fixed program slot skips the divide. a bank
// update has no character loads when the character bank count is zero;
// initialize adds one mirroring word.
// reset (synchronous, active high) returns config and mapper state to their
// defaults and empties the output register.
// a stalled output holds its word; the sequencer waits in its load step,
// while a new input word is still taken once the last result is queued.
module bank_switch_irq_mapper_core #(
  parameter int CYCLE_PRESCALE = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // input word channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [15:0]                    address,
  input  logic [7:0]                     data,
  input  logic [7:0]                     cycles,
  input  logic                           rendering_on,
  // result word channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     action,
  output logic [2:0]                     slot,
  output logic [7:0]                     bank,
  output logic                           last,
  // configuration writes
  input  logic                           cfg_write,
  input  logic [bsim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  bsim_pkg::ctrl_cmd_t  cmd;
  bsim_pkg::dp_status_t status;

  // sequencer: owns the request flow and the slot index
  bsim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // state, remainder unit and output register
  bsim_dp #(
    .CYCLE_PRESCALE (CYCLE_PRESCALE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .address      (address),
    .data         (data),
    .cycles       (cycles),
    .rendering_on (rendering_on),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .action       (action),
    .slot         (slot),
    .bank         (bank),
    .last         (last)
  );

endmodule

/* design/bsim_chk.sv */
// port-level checker for the mapper core, bound to the top level
module bsim_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] action,
  input logic [2:0] slot,
  input logic [7:0] bank,
  input logic       last
);

  // reset leaves the block idle with nothing queued
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({action, slot, bank, last}))
    else $error("stalled result changed");

  // a new result only appears while a request is in work
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in work");

  // interrupt raise and clear are single-word results
  a_irq_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == bsim_pkg::ACT_RAISE || action == bsim_pkg::ACT_CLEAR)
      |-> last && slot == 3'd0 && bank == 8'd0)
    else $error("interrupt result not a lone word");

endmodule

bind bank_switch_irq_mapper_core bsim_chk u_chk (.*);
